FILE: hdl/bit_packing_fifo_macros.svh
// Assertion macros shared by the bit packing FIFO modules.
`ifndef BIT_PACKING_FIFO_MACROS_SVH
`define BIT_PACKING_FIFO_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define BPF_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define BPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define BPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bpf_pkg.sv
// Shared types and constants of the bit packing FIFO.
`timescale 1ns / 1ps
`default_nettype none

package bpf_pkg;

    localparam int unsigned STORE_BYTES = 512;
    localparam int unsigned CAP_BITS    = STORE_BYTES * 8;
    localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
    localparam int unsigned POS_W       = $clog2(CAP_BITS);
    localparam int unsigned CNT_W       = $clog2(CAP_BITS + 1);
    localparam int unsigned HELD_W      = 13;

    typedef enum logic [2:0] {
        CMD_WR_BIT  = 3'd0,
        CMD_RD_BIT  = 3'd1,
        CMD_WR_BYTE = 3'd2,
        CMD_RD_BYTE = 3'd3,
        CMD_WR_WORD = 3'd4,
        CMD_RD_WORD = 3'd5,
        CMD_CLEAR   = 3'd6
    } t_cmd;

    typedef logic [HELD_W-1:0] t_bits_held;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_value;
        t_bits_held  bits_held;
        logic        underflow;
        logic        overflow;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic plan;
        logic step;
        logic finish;
    } t_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic access_done;
    } t_stat;

endpackage

`default_nettype wire

FILE: hdl/bpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bpf_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/bpf_ctrl.sv
// Controller state machine of the bit packing FIFO.
`timescale 1ns / 1ps
`default_nettype none
`include "bit_packing_fifo_macros.svh"

module bpf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               o_valid,
    output bpf_pkg::t_ctrl     o_ctrl,
    input  wire bpf_pkg::t_stat i_stat
);
    import bpf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAN,
        ST_ACCESS,
        ST_FINISH
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_valid <= 1'b0;
                    if (start) begin
                        r_state <= ST_PLAN;
                        r_busy  <= 1'b1;
                    end
                end
                ST_PLAN: begin
                    r_state <= ST_ACCESS;
                end
                ST_ACCESS: begin
                    if (i_stat.access_done) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_ctrl.load   = start && !r_busy;
        o_ctrl.plan   = (r_state == ST_PLAN);
        o_ctrl.step   = (r_state == ST_ACCESS);
        o_ctrl.finish = (r_state == ST_FINISH);
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;

    `BPF_ASSERT_SAME(a_busy_matches_state, r_busy, r_state != ST_IDLE, "busy out of step with state")
    `BPF_ASSERT_NEXT(a_finish_strobes, r_state == ST_FINISH, r_valid && !r_busy, "missing result strobe")
    `BPF_ASSERT_NEXT(a_valid_one_cycle, r_valid, !r_valid, "result strobe longer than a cycle")

endmodule

`default_nettype wire

FILE: hdl/bpf_dpath.sv
// Datapath of the bit packing FIFO: positions, byte store access and result.
`timescale 1ns / 1ps
`default_nettype none
`include "bit_packing_fifo_macros.svh"

module bpf_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bpf_pkg::t_ctrl     i_ctrl,
    input  wire bpf_pkg::t_in_item  i_item,
    output bpf_pkg::t_stat          o_stat,
    output bpf_pkg::t_out_item      o_item
);
    import bpf_pkg::*;

    // A 32-bit access at any bit offset spans at most five bytes.
    localparam int unsigned LANES = 5;
    localparam int unsigned WIN_W = LANES * 8;
    localparam logic [POS_W:0]    CAP_P    = (POS_W + 1)'(CAP_BITS);
    localparam logic [CNT_W-1:0]  CAP_C    = CNT_W'(CAP_BITS);
    localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(STORE_BYTES - 1);

    function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
        return (a == LAST_ADR) ? '0 : a + ADDR_W'(1);
    endfunction

    logic [2:0]               r_cmd;
    logic [31:0]              r_data;
    logic [POS_W-1:0]         r_wp;
    logic [POS_W-1:0]         r_rp;
    logic [CNT_W-1:0]         r_count;
    logic [5:0]               r_neff;
    logic [2:0]               r_off;
    logic [2:0]               r_nb;
    logic                     r_unf;
    logic                     r_ovf;
    logic [2:0]               r_krd;
    logic [2:0]               r_kwr;
    logic                     r_pend;
    logic [ADDR_W-1:0]        r_ard;
    logic [ADDR_W-1:0]        r_awr;
    logic [0:LANES-1][7:0]    r_lane;
    t_out_item                r_out;

    logic                     is_wr;
    logic                     is_rd;
    logic [5:0]               n_req;
    logic [CNT_W-1:0]         avail;
    logic                     short_n;
    logic [5:0]               neff;
    logic [2:0]               off;
    logic [6:0]               span;
    logic [WIN_W-1:0]         lead;
    logic [WIN_W-1:0]         wval;
    logic [0:LANES-1][7:0]    m_lanes;
    logic [0:LANES-1][7:0]    w_lanes;
    logic [WIN_W-1:0]         rwin;
    logic                     issue;
    logic                     ram_we;
    logic                     ram_re;
    logic [7:0]               ram_q;
    logic [7:0]               ram_wdata;
    logic [POS_W:0]           wsum;
    logic [POS_W:0]           rsum;
    logic [CNT_W-1:0]         count_next;
    logic [31:0]              value;

    always_comb begin
        is_wr = (r_cmd == CMD_WR_BIT) || (r_cmd == CMD_WR_BYTE) || (r_cmd == CMD_WR_WORD);
        is_rd = (r_cmd == CMD_RD_BIT) || (r_cmd == CMD_RD_BYTE) || (r_cmd == CMD_RD_WORD);
        unique case (r_cmd)
            CMD_WR_BIT, CMD_RD_BIT:   n_req = 6'd1;
            CMD_WR_BYTE, CMD_RD_BYTE: n_req = 6'd8;
            CMD_WR_WORD, CMD_RD_WORD: n_req = 6'd32;
            default:                  n_req = 6'd0;
        endcase
        // Writes are limited by free room, reads by the bits held.
        avail   = is_wr ? (CAP_C - r_count) : r_count;
        short_n = avail < CNT_W'(n_req);
        neff    = short_n ? avail[5:0] : n_req;
        off     = is_wr ? r_wp[2:0] : r_rp[2:0];
        span    = 7'(off) + 7'(neff) + 7'd7;
    end

    // Window of five bytes, first byte in the top lane; bits before the
    // offset and past the effective length are outside the mask.
    always_comb begin
        lead = ~({WIN_W{1'b1}} >> r_neff);
        wval = '0;
        unique case (r_cmd)
            CMD_WR_BIT:  wval[WIN_W-1]      = r_data[0];
            CMD_WR_BYTE: wval[WIN_W-1 -: 8]  = r_data[7:0];
            CMD_WR_WORD: wval[WIN_W-1 -: 32] = r_data;
            default:     wval                = '0;
        endcase
        m_lanes = lead >> r_off;
        w_lanes = wval >> r_off;
    end

    assign issue      = r_krd < r_nb;
    assign ram_re     = i_ctrl.step && issue;
    assign ram_we     = i_ctrl.step && r_pend && is_wr;
    assign ram_wdata  = (ram_q & ~m_lanes[r_kwr]) | (w_lanes[r_kwr] & m_lanes[r_kwr]);
    assign o_stat.access_done = !issue && !r_pend;

    bpf_ram #(
        .W     (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_awr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ard),
        .o_rdata (ram_q)
    );

    always_comb begin
        rwin = (r_lane << r_off) & lead;
        unique case (r_cmd)
            CMD_RD_BIT:  value = {31'd0, rwin[WIN_W-1]};
            CMD_RD_BYTE: value = {24'd0, rwin[WIN_W-1 -: 8]};
            CMD_RD_WORD: value = rwin[WIN_W-1 -: 32];
            default:     value = '0;
        endcase
        wsum = {1'b0, r_wp} + (POS_W + 1)'(r_neff);
        rsum = {1'b0, r_rp} + (POS_W + 1)'(r_neff);
        if (wsum >= CAP_P) begin
            wsum = wsum - CAP_P;
        end
        if (rsum >= CAP_P) begin
            rsum = rsum - CAP_P;
        end
        priority if (r_cmd == CMD_CLEAR) begin
            count_next = '0;
        end else if (is_wr) begin
            count_next = r_count + CNT_W'(r_neff);
        end else if (is_rd) begin
            count_next = r_count - CNT_W'(r_neff);
        end else begin
            count_next = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_krd   <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_ctrl.load) begin
                r_cmd  <= i_item.command;
                r_data <= i_item.data;
            end
            if (i_ctrl.plan) begin
                r_neff <= neff;
                r_off  <= off;
                // An item that moves no bits touches no byte.
                r_nb   <= (neff == 6'd0) ? 3'd0 : span[5:3];
                r_unf  <= is_rd && short_n;
                r_ovf  <= is_wr && short_n;
                r_ard  <= is_wr ? r_wp[POS_W-1:3] : r_rp[POS_W-1:3];
                r_awr  <= is_wr ? r_wp[POS_W-1:3] : r_rp[POS_W-1:3];
                r_krd  <= '0;
                r_pend <= 1'b0;
                r_lane <= '0;
            end
            // Read of the next byte overlaps the merge of the previous one.
            if (i_ctrl.step) begin
                r_pend <= issue;
                r_kwr  <= r_krd;
                if (issue) begin
                    r_krd <= r_krd + 3'd1;
                    r_ard <= next_addr(r_ard);
                end
                if (r_pend) begin
                    r_awr <= next_addr(r_awr);
                    if (is_rd) begin
                        r_lane[r_kwr] <= ram_q;
                    end
                end
            end
            if (i_ctrl.finish) begin
                r_count <= count_next;
                if (r_cmd == CMD_CLEAR) begin
                    r_wp <= '0;
                    r_rp <= '0;
                end else begin
                    if (is_wr) begin
                        r_wp <= wsum[POS_W-1:0];
                    end
                    if (is_rd) begin
                        r_rp <= rsum[POS_W-1:0];
                    end
                end
                r_out.read_value <= value;
                r_out.bits_held  <= t_bits_held'(count_next);
                r_out.underflow  <= r_unf;
                r_out.overflow   <= r_ovf;
            end
        end
    end

    assign o_item = r_out;

    `BPF_ASSERT_ALWAYS(a_count_in_range, r_count <= CAP_C, "bit count above capacity")
    `BPF_ASSERT_ALWAYS(a_byte_index_range, r_krd <= 3'(LANES), "byte index past window")
    `BPF_ASSERT_SAME(a_no_port_clash, ram_we && ram_re, r_awr != r_ard, "read and write same byte")

endmodule

`default_nettype wire

FILE: hdl/bit_packing_fifo.sv
// Top level of the bit packing FIFO.
//
// A command is taken at a clock edge where start is high and busy is low;
// busy then stays high while the item works, and its result appears on
// o_item for exactly one cycle with o_valid high, in the first cycle busy
// is low again. The receiver cannot stall, so the result must be captured
// in that cycle; a new command may be issued in the same cycle. An item
// that moves no bits (clear, an unused code, a read of an empty store or a
// write to a full one) touches no stored byte; any other item touches the
// stored bytes that its moved bits fall in (1 for a bit, 1 or 2 for a byte,
// 4 or 5 for a word, fewer when the access is cut short). The byte store
// has one read and one write port, and one byte is fetched per cycle with
// registered read data. The controller plans the item, steps through the
// store access until the datapath reports it done, makes the final update
// and then shows the result. The store needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module bit_packing_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire bpf_pkg::t_in_item  i_item,
    output logic                    busy,
    output logic                    o_valid,
    output bpf_pkg::t_out_item      o_item
);
    import bpf_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    bpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_ctrl  (ctrl),
        .i_stat  (stat)
    );

    bpf_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_item  (i_item),
        .o_stat  (stat),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the bit packing FIFO against a shadow model.
`timescale 1ns / 1ps

module tb_top;
    import bpf_pkg::*;

    localparam logic [2:0]  CMD_UNUSED   = 3'd7;
    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct {
        t_in_item    item;
        int unsigned gap;
        bit          hold;
    } t_pending;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_item;

    bit_packing_fifo dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    // Commands waiting to be sent and results still to come back.
    t_pending    pending_cmds[$];
    t_out_item   expected_results[$];
    int unsigned total_cmds;
    int unsigned accepted_cmds;
    int unsigned errors;
    int unsigned cycle_count;

    // Generator state: the bit count the queued commands will leave behind.
    int unsigned planned_held;
    int unsigned quiet_left;

    // Shadow copy of the FIFO contents.
    logic [7:0]  shadow_store [STORE_BYTES];
    int unsigned shadow_wr_pos;
    int unsigned shadow_rd_pos;
    int unsigned shadow_held;

    function automatic int unsigned access_width(logic [2:0] cmd);
        case (cmd)
            CMD_WR_BIT, CMD_RD_BIT:   return 1;
            CMD_WR_BYTE, CMD_RD_BYTE: return 8;
            CMD_WR_WORD, CMD_RD_WORD: return 32;
            default:                  return 0;
        endcase
    endfunction

    function automatic bit store_bit(bit b);
        if (shadow_held >= CAP_BITS) return 1'b0;
        shadow_store[shadow_wr_pos / 8][7 - (shadow_wr_pos % 8)] = b;
        shadow_wr_pos = (shadow_wr_pos + 1) % CAP_BITS;
        shadow_held++;
        return 1'b1;
    endfunction

    function automatic bit fetch_bit(output bit b);
        b = 1'b0;
        if (shadow_held == 0) return 1'b0;
        b = shadow_store[shadow_rd_pos / 8][7 - (shadow_rd_pos % 8)];
        shadow_rd_pos = (shadow_rd_pos + 1) % CAP_BITS;
        shadow_held--;
        return 1'b1;
    endfunction

    function automatic t_out_item predict_fifo(t_in_item it);
        t_out_item   res;
        int unsigned n;
        bit          b;
        res = '0;
        n = access_width(it.command);
        case (it.command)
            CMD_WR_BIT, CMD_WR_BYTE, CMD_WR_WORD: begin
                // The most significant bit of the access goes in first.
                for (int i = int'(n) - 1; i >= 0; i--) begin
                    if (!store_bit(it.data[i])) res.overflow = 1'b1;
                end
            end
            CMD_RD_BIT, CMD_RD_BYTE, CMD_RD_WORD: begin
                for (int i = 0; i < int'(n); i++) begin
                    if (!fetch_bit(b)) res.underflow = 1'b1;
                    res.read_value = {res.read_value[30:0], b};
                end
            end
            CMD_CLEAR: begin
                shadow_wr_pos = 0;
                shadow_rd_pos = 0;
                shadow_held   = 0;
            end
            default: ;
        endcase
        res.bits_held = t_bits_held'(shadow_held);
        return res;
    endfunction

    task automatic add_cmd(input logic [2:0] cmd, input logic [31:0] data, input bit hold);
        t_pending    p;
        int unsigned n;
        p.item.command = cmd;
        p.item.data    = data;
        p.hold         = hold;
        if (quiet_left > 0) begin
            quiet_left--;
            p.gap = 0;
        end else if ($urandom_range(0, 99) == 0) begin
            quiet_left = $urandom_range(10, 40);
            p.gap = 0;
        end else if ($urandom_range(0, 3) == 0) begin
            p.gap = 0;
        end else begin
            p.gap = $urandom_range(0, 12);
        end
        n = access_width(cmd);
        case (cmd)
            CMD_WR_BIT, CMD_WR_BYTE, CMD_WR_WORD:
                planned_held = (planned_held + n > CAP_BITS) ? CAP_BITS : planned_held + n;
            CMD_RD_BIT, CMD_RD_BYTE, CMD_RD_WORD:
                planned_held = (planned_held > n) ? planned_held - n : 0;
            CMD_CLEAR:
                planned_held = 0;
            default: ;
        endcase
        pending_cmds.insert(pending_cmds.size(), p);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Driver: presents the queued commands, keeping each one up until it is taken.
    t_pending    next_cmd;
    bit          have_next;
    int unsigned gap_left;
    logic        cmd_taken = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !cmd_taken) begin
            // The block has not taken the current item yet.
        end else begin
            if (!have_next && pending_cmds.size() != 0) begin
                next_cmd  = pending_cmds[0];
                pending_cmds.delete(0);
                gap_left  = next_cmd.gap;
                have_next = 1'b1;
            end
            if (!have_next || gap_left != 0 ||
                (next_cmd.hold && expected_results.size() != 0)) begin
                start <= 1'b0;
                if (have_next && gap_left != 0) gap_left--;
            end else begin
                start     <= 1'b1;
                i_item    <= next_cmd.item;
                have_next = 1'b0;
            end
        end
    end

    // Monitor: checks each result, then predicts the item taken at this edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: got %p", $time, o_item);
                    errors++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (o_item.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %h got %h",
                                 $time, want.read_value, o_item.read_value);
                        errors++;
                    end
                    if (o_item.bits_held !== want.bits_held) begin
                        $display("%0t: bits_held expected %0d got %0d",
                                 $time, want.bits_held, o_item.bits_held);
                        errors++;
                    end
                    if (o_item.underflow !== want.underflow) begin
                        $display("%0t: underflow expected %b got %b",
                                 $time, want.underflow, o_item.underflow);
                        errors++;
                    end
                    if (o_item.overflow !== want.overflow) begin
                        $display("%0t: overflow expected %b got %b",
                                 $time, want.overflow, o_item.overflow);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                expected_results.insert(expected_results.size(), predict_fifo(i_item));
                accepted_cmds++;
            end
        end
        cmd_taken <= i_rst_n && start && !busy;
    end

    initial begin
        logic [2:0] cmd;
        bit         draining;
        bit         is_wr;
        int unsigned roll;

        foreach (shadow_store[i]) shadow_store[i] = '0;

        // Directed part. Bytes 0 to 15 are written first so that the short
        // reads and the read past the end below only touch written bytes.
        for (int i = 0; i < 4; i++) add_cmd(CMD_WR_WORD, $urandom(), 1'b0);
        add_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1);
        add_cmd(CMD_WR_WORD, 32'hFFFF_FFFF, 1'b0);
        add_cmd(CMD_WR_WORD, 32'h0000_0000, 1'b0);
        add_cmd(CMD_WR_WORD, 32'h8000_0001, 1'b0);
        add_cmd(CMD_WR_BYTE, 32'hFFFF_FF80, 1'b0);
        add_cmd(CMD_WR_BIT, 32'hFFFF_FFFF, 1'b0);
        add_cmd(CMD_WR_BIT, 32'hFFFF_FFFE, 1'b0);
        add_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 1'b0);
        add_cmd(CMD_RD_BIT, 32'hFFFF_FFFF, 1'b0);
        add_cmd(CMD_RD_BYTE, 32'h0000_0000, 1'b0);
        add_cmd(CMD_RD_WORD, 32'hFFFF_FFFF, 1'b0);
        add_cmd(CMD_RD_WORD, 32'h0000_0000, 1'b0);
        add_cmd(CMD_RD_BYTE, 32'hFFFF_FFFF, 1'b0);
        // Fewer bits are held than a word, so this read runs past the end.
        add_cmd(CMD_RD_WORD, 32'h0000_0000, 1'b0);
        add_cmd(CMD_RD_BIT, 32'h0000_0000, 1'b0);

        // Fill the whole store once, which also writes every byte, and then
        // push past capacity.
        for (int i = 0; i < int'(CAP_BITS / 32); i++) add_cmd(CMD_WR_WORD, $urandom(), 1'b0);
        add_cmd(CMD_WR_BIT, 32'hFFFF_FFFF, 1'b0);
        add_cmd(CMD_WR_WORD, $urandom(), 1'b0);

        // Random part: swings between filling and draining so that both the
        // full and the empty store are reached again and again.
        draining = 1'b1;
        for (int k = 0; k < int'(RANDOM_ITEMS); k++) begin
            if (planned_held >= CAP_BITS && $urandom_range(0, 2) == 0) begin
                draining = 1'b0 == 1'b0;
            end else if (planned_held == 0 && $urandom_range(0, 2) == 0) begin
                draining = 1'b0;
            end else if ($urandom_range(0, 299) == 0) begin
                draining = !draining;
            end
            roll = $urandom_range(0, 99);
            if (draining && planned_held < 64 && roll < 10) begin
                cmd = CMD_CLEAR;
            end else if (roll >= 98) begin
                cmd = CMD_UNUSED;
            end else begin
                is_wr = ($urandom_range(0, 99) < (draining ? 20 : 80));
                case ($urandom_range(0, 2))
                    0:       cmd = is_wr ? CMD_WR_BIT : CMD_RD_BIT;
                    1:       cmd = is_wr ? CMD_WR_BYTE : CMD_RD_BYTE;
                    default: cmd = is_wr ? CMD_WR_WORD : CMD_RD_WORD;
                endcase
            end
            add_cmd(cmd, $urandom(), $urandom_range(0, 199) == 0);
        end
        total_cmds = pending_cmds.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cmds < total_cmds || expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
